/* design/event_log_ring_buffer_top_macros.svh */
// Assertion macros shared by the event log checker.
`ifndef EVENT_LOG_RING_BUFFER_TOP_MACROS_SVH
`define EVENT_LOG_RING_BUFFER_TOP_MACROS_SVH

// Flag a violation whenever ante holds and cons does not in the same cycle.
`define ELRB_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Flag a violation whenever ante holds and cons does not in the cycle after.
`define ELRB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/elrb_pkg.sv */
package elrb_pkg;

  localparam int ENTRY_PORT_W = 64;
  localparam int FUNC_W       = 2;
  localparam int COUNT_W      = 5;
  localparam int OVF_W        = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QFILL_W      = $clog2(QDEPTH + 1);

  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  // request function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DUMP  = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_CLEAR,
    OP_DUMP,
    OP_NOP
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOG_ENABLE = 1'b0,
    REG_LOG_MODE   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    op_t                     op;
    logic [ENTRY_PORT_W-1:0] data;
  } queue_item_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_SEND = 3'b100
  } back_state_t;

endpackage

/* design/elrb_ram.sv */
module elrb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/elrb_front.sv */
module elrb_front import elrb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       func,
  input  logic [ENTRY_PORT_W-1:0] entry_data,
  output logic                    q_valid,
  output queue_item_t             q_item,
  input  logic                    q_pop
);

  queue_item_t        slot [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               push;
  op_t                op_class;

  // classify the request; unknown codes become a status-only request
  always_comb begin
    case (func)
      FUNC_ADD:   op_class = OP_ADD;
      FUNC_CLEAR: op_class = OP_CLEAR;
      FUNC_DUMP:  op_class = OP_DUMP;
      default:    op_class = OP_NOP;
    endcase
  end

  assign in_ready = (fill != QFILL_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{op: op_class, data: entry_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        fill <= fill + QFILL_W'(1);
      end else if (!push && q_pop) begin
        fill <= fill - QFILL_W'(1);
      end
    end
  end

endmodule

/* design/elrb_back.sv */
module elrb_back import elrb_pkg::*; #(
  parameter int LOG_DEPTH   = 16,
  parameter int ENTRY_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  queue_item_t             q_item,
  output logic                    q_pop,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic                    cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ENTRY_PORT_W-1:0] out_entry,
  output logic                    entry_valid,
  output logic                    out_last,
  output logic [COUNT_W-1:0]      entry_count,
  output logic                    full_flag,
  output logic [OVF_W-1:0]        overflow_count
);

  localparam int PW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);

  back_state_t       state;
  logic [PW-1:0]     wp;
  logic [CW-1:0]     cnt;
  logic              full;
  logic [OVF_W-1:0]  ovf;
  logic              log_enable;
  logic              log_mode;
  logic [PW-1:0]     rd_idx;
  logic [CW-1:0]     remain;

  logic [PW-1:0]          wp_next;
  logic [CW-1:0]          cnt_next;
  logic                   full_next;
  logic [OVF_W-1:0]       ovf_next;
  logic                   add_store;
  logic [PW-1:0]          wp_inc;
  logic [PW-1:0]          rd_inc;
  logic [OVF_W-1:0]       ovf_inc;
  logic                   out_free;
  logic                   take;
  logic                   dump_start;
  logic                   load_status;
  logic                   load_entry;
  logic [ENTRY_WIDTH-1:0] ram_rdata;

  assign wp_inc  = (wp == PW'(LOG_DEPTH - 1)) ? '0 : wp + PW'(1);
  assign rd_inc  = (rd_idx == PW'(LOG_DEPTH - 1)) ? '0 : rd_idx + PW'(1);
  assign ovf_inc = (ovf == OVF_MAX) ? ovf : ovf + OVF_W'(1);

  // post-operation state for add and clear
  always_comb begin
    wp_next   = wp;
    cnt_next  = cnt;
    full_next = full;
    ovf_next  = ovf;
    add_store = 1'b0;
    case (q_item.op)
      OP_ADD: begin
        if (log_enable) begin
          if (full) begin
            ovf_next = ovf_inc;
          end
          if (!(full && log_mode)) begin
            add_store = 1'b1;
            wp_next   = wp_inc;
            if (cnt != CW'(LOG_DEPTH)) begin
              cnt_next  = cnt + CW'(1);
              full_next = (cnt == CW'(LOG_DEPTH - 1));
            end
          end
        end
      end
      OP_CLEAR: begin
        wp_next   = '0;
        cnt_next  = '0;
        full_next = 1'b0;
        ovf_next  = '0;
      end
      default: ;
    endcase
  end

  assign out_free    = !out_valid || out_ready;
  assign take        = (state == ST_IDLE) && q_valid && out_free;
  assign q_pop       = take;
  assign dump_start  = take && (q_item.op == OP_DUMP) && (cnt != '0);
  assign load_status = take && !dump_start;
  assign load_entry  = (state == ST_SEND) && out_free;

  elrb_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (LOG_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (take && add_store),
    .waddr (wp),
    .wdata (q_item.data[ENTRY_WIDTH-1:0]),
    .re    (state == ST_READ),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      cnt        <= '0;
      full       <= 1'b0;
      ovf        <= '0;
      log_enable <= 1'b1;
      log_mode   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LOG_ENABLE: log_enable <= cfg_data;
          REG_LOG_MODE:   log_mode   <= cfg_data;
          default: ;
        endcase
      end
      if (take) begin
        wp   <= wp_next;
        cnt  <= cnt_next;
        full <= full_next;
        ovf  <= ovf_next;
      end
      case (state)
        ST_IDLE: begin
          if (dump_start) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_SEND;
        end
        ST_SEND: begin
          if (load_entry) begin
            state <= (remain == CW'(1)) ? ST_IDLE : ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_status || load_entry) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // dump walk position and result payload
  always_ff @(posedge clk) begin
    if (dump_start) begin
      rd_idx <= full ? wp : '0;
      remain <= cnt;
    end else if (load_entry) begin
      rd_idx <= rd_inc;
      remain <= remain - CW'(1);
    end
    if (load_status) begin
      out_entry      <= '0;
      entry_valid    <= 1'b0;
      out_last       <= 1'b1;
      entry_count    <= COUNT_W'(cnt_next);
      full_flag      <= full_next;
      overflow_count <= ovf_next;
    end else if (load_entry) begin
      out_entry      <= ENTRY_PORT_W'(ram_rdata);
      entry_valid    <= 1'b1;
      out_last       <= (remain == CW'(1));
      entry_count    <= COUNT_W'(cnt);
      full_flag      <= full;
      overflow_count <= ovf;
    end
  end

endmodule

/* design/event_log_ring_buffer_top.sv */
// Event log ring buffer. Holds up to LOG_DEPTH entries of ENTRY_WIDTH bits
// (entry_data is cut to its low ENTRY_WIDTH bits, out_entry zero-extended)
// and serves three requests selected by func: add, clear and dump. Add and
// clear, and an unknown func code, each answer with one status result
// (entry_valid 0, out_last 1) carrying the entry count, full flag and the
// saturating overflow count as they stand after the request. With
// log_enable low an add changes nothing. When the log is full, log_mode 0
// overwrites the oldest entry and log_mode 1 drops the new one; both count
// an overflow. Dump returns the held entries oldest first with out_last on
// the newest, or a single status result when the log is empty. Requests
// land in a two-deep queue, so up to two requests are taken while the
// executing side works or waits on out_ready; in_ready then drops until one
// leaves the queue. Add and clear sustain one request per clock while
// out_ready stays high, each passing through the queue and a registered
// result. A dump walks the ST_READ and ST_SEND states for each entry,
// reading the entry store through its registered read port; later requests
// wait in the queue meanwhile. Write the configuration registers only
// while the block is idle; cfg_ready is always high.
module event_log_ring_buffer_top import elrb_pkg::*; #(
  parameter int LOG_DEPTH   = 16,
  parameter int ENTRY_WIDTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [FUNC_W-1:0]       func,
  input  logic [ENTRY_PORT_W-1:0] entry_data,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic                    cfg_data,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ENTRY_PORT_W-1:0] out_entry,
  output logic                    entry_valid,
  output logic                    out_last,
  output logic [COUNT_W-1:0]      entry_count,
  output logic                    full_flag,
  output logic [OVF_W-1:0]        overflow_count
);

  logic        q_valid;
  logic        q_pop;
  queue_item_t q_item;

  // the user must write registers only while idle (not enforced here), so take every write at once
  assign cfg_ready = 1'b1;

  // front: accept and classify requests, hold them in the queue
  elrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .entry_data (entry_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // back: execute requests against the log state and drive results
  elrb_back #(
    .LOG_DEPTH   (LOG_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_entry      (out_entry),
    .entry_valid    (entry_valid),
    .out_last       (out_last),
    .entry_count    (entry_count),
    .full_flag      (full_flag),
    .overflow_count (overflow_count)
  );

endmodule

/* design/elrb_checker.sv */
`include "event_log_ring_buffer_top_macros.svh"

module elrb_checker import elrb_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [ENTRY_PORT_W-1:0] out_entry,
  input logic                    entry_valid,
  input logic                    out_last,
  input logic [COUNT_W-1:0]      entry_count,
  input logic                    full_flag
);

  logic status_out;
  logic dumped_out;
  logic out_stall;
  logic zero_entry;
  logic held_any;

  assign status_out = out_valid && !entry_valid;
  assign dumped_out = out_valid && entry_valid;
  assign out_stall  = out_valid && !out_ready;
  assign zero_entry = (out_entry == '0);
  assign held_any   = (entry_count != '0) || full_flag;

  // a result with no entry is always the only result of its request
  `ELRB_ASSERT_SAME(a_status_is_last, clk, rst, status_out, out_last, "status not last")

  // a result with no entry carries a zero entry field
  `ELRB_ASSERT_SAME(a_status_zero_entry, clk, rst, status_out, zero_entry, "status entry set")

  // a dumped entry implies the log holds something
  `ELRB_ASSERT_SAME(a_dump_nonempty, clk, rst, dumped_out, held_any, "dump from empty log")

  // a stalled result holds its entry
  `ELRB_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_entry), "stall moved")

endmodule

bind event_log_ring_buffer_top elrb_checker u_elrb_checker (.*);
